>>> hdl/cpu_freq_limit_aggregator_defines.svh
// assertion macros for the cpu frequency limit aggregator
// no dependencies; included by the top level only
`ifndef CPU_FREQ_LIMIT_AGGREGATOR_DEFINES_SVH
`define CPU_FREQ_LIMIT_AGGREGATOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define CFLA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled during reset
`define CFLA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CFLA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CFLA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/cfla_pkg.sv
// shared types and constants of the cpu frequency limit aggregator
// no dependencies; used by the controller, datapath and top level
`timescale 1ns / 1ps

package cfla_pkg;

    // command codes of an input transaction
    typedef enum logic [2:0] {
        CMD_SET_MIN      = 3'd0,
        CMD_SET_USER_MAX = 3'd1,
        CMD_SET_OVER_MAX = 3'd2,
        CMD_READ_MIN     = 3'd3,
        CMD_READ_MAX     = 3'd4
    } t_cmd;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LITTLE_MAX_FREQ   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LITTLE_DIVIDER    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LITTLE_LOCK_FLOOR = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIG_LOCK_CEILING  = 2'd3;

    // configuration reset values
    localparam int unsigned RST_LITTLE_MAX_FREQ   = 1800000;
    localparam int unsigned RST_LITTLE_DIVIDER    = 4;
    localparam int unsigned RST_LITTLE_LOCK_FLOOR = 1175000;
    localparam int unsigned RST_BIG_LOCK_CEILING  = 850000;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TH_ISSUE,
        S_TH_WAIT,
        S_WRITE,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_RD_ACC,
        S_OUT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic latch_item;
        logic sel_entry;
        logic write_entry;
        logic acc_clear;
        logic acc_step;
        logic idx_clear;
        logic idx_inc;
        logic out_load;
    } t_ctrl;

    // status from datapath to controller
    typedef struct packed {
        logic cmd_set;
        logic cmd_read;
        logic idx_last;
        logic out_free;
    } t_stat;

endpackage

>>> hdl/cfla_divider.sv
// two-stage divider by a small divisor (1..15) using a reciprocal table
// no package dependency; instantiated by cfla_datapath
`timescale 1ns / 1ps

module cfla_divider #(
    parameter int FREQ_BITS = 22
) (
    input  logic                  i_clk,
    input  logic [FREQ_BITS+3:0]  i_x,
    input  logic [3:0]            i_d,
    output logic [FREQ_BITS+3:0]  o_q
);

    localparam int XW = FREQ_BITS + 4;
    localparam int KW = XW + 1;
    localparam int PW = XW + KW;
    localparam int RW = XW + 4;
    localparam logic [63:0] ONE_K = (64'd1 << KW) - 64'd1;

    // floor((2^KW - 1) / d), index zero never used
    localparam logic [KW-1:0] RECIP [16] = '{
        KW'(ONE_K),         KW'(ONE_K / 64'd1),  KW'(ONE_K / 64'd2),  KW'(ONE_K / 64'd3),
        KW'(ONE_K / 64'd4),  KW'(ONE_K / 64'd5),  KW'(ONE_K / 64'd6),  KW'(ONE_K / 64'd7),
        KW'(ONE_K / 64'd8),  KW'(ONE_K / 64'd9),  KW'(ONE_K / 64'd10), KW'(ONE_K / 64'd11),
        KW'(ONE_K / 64'd12), KW'(ONE_K / 64'd13), KW'(ONE_K / 64'd14), KW'(ONE_K / 64'd15)
    };

    logic [XW-1:0] r_x;
    logic [3:0]    r_d;
    logic [PW-1:0] r_prod;
    logic [XW-1:0] r_q;

    logic [XW-1:0] w_q0;
    logic [RW-1:0] w_qd;
    logic [RW-1:0] w_rem;

    // stage one: multiply by reciprocal
    always_ff @(posedge i_clk) begin
        r_x    <= i_x;
        r_d    <= i_d;
        r_prod <= PW'(i_x) * PW'(RECIP[i_d]);
    end

    // estimate is low by at most one; fix with the remainder
    always_comb begin
        w_q0  = r_prod[PW-1:KW];
        w_qd  = RW'(w_q0) * RW'(r_d);
        w_rem = RW'(r_x) - w_qd;
    end

    // stage two: corrected quotient
    always_ff @(posedge i_clk) begin
        r_q <= (w_rem >= RW'(r_d)) ? (w_q0 + XW'(1)) : w_q0;
    end

    assign o_q = r_q;

endmodule

>>> hdl/cfla_datapath.sv
// datapath: config registers, limit tables, boost flags, read accumulator, result register
// depends on cfla_pkg and cfla_divider
`timescale 1ns / 1ps

module cfla_datapath #(
    parameter int NUM_REQUESTERS  = 8,
    parameter int USER_INDEX      = 0,
    parameter int TOUCH_INDEX     = 1,
    parameter int FINGER_INDEX    = 2,
    parameter int OVERLIMIT_INDEX = 3,
    parameter int FREQ_BITS       = 22
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cfla_pkg::t_ctrl                    i_ctrl,
    output cfla_pkg::t_stat                    o_stat,
    input  logic                               i_cfg_valid,
    input  logic [cfla_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [FREQ_BITS-1:0]               i_cfg_data,
    input  logic [2:0]                         i_cmd,
    input  logic [2:0]                         i_req,
    input  logic signed [FREQ_BITS:0]          i_freq,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_status,
    output logic signed [FREQ_BITS:0]          o_read_value,
    output logic                               o_boost,
    output logic                               o_notify,
    output logic signed [FREQ_BITS+3:0]        o_little_min,
    output logic signed [FREQ_BITS+3:0]        o_big_min,
    output logic signed [FREQ_BITS+3:0]        o_little_max,
    output logic signed [FREQ_BITS+3:0]        o_big_max
);

    localparam int IDX_W = $clog2(NUM_REQUESTERS);
    localparam int XW    = FREQ_BITS + 4;
    localparam int EW    = XW + 1;
    localparam int OW    = FREQ_BITS + 4;
    localparam int RW    = FREQ_BITS + 1;
    localparam bit USER_OK = (USER_INDEX < NUM_REQUESTERS);
    localparam bit OVER_OK = (OVERLIMIT_INDEX < NUM_REQUESTERS);

    // configuration
    logic [FREQ_BITS-1:0] r_little_max_freq;
    logic [3:0]           r_little_divider;
    logic [FREQ_BITS-1:0] r_little_lock_floor;
    logic [FREQ_BITS-1:0] r_big_lock_ceiling;

    // latched item
    logic [2:0]              r_cmd;
    logic [2:0]              r_req;
    logic signed [FREQ_BITS:0] r_freq;

    // limit tables, all ones means no limit
    logic signed [EW-1:0] r_lmin [NUM_REQUESTERS];
    logic signed [EW-1:0] r_bmin [NUM_REQUESTERS];
    logic signed [EW-1:0] r_lmax [NUM_REQUESTERS];
    logic signed [EW-1:0] r_bmax [NUM_REQUESTERS];
    logic [NUM_REQUESTERS-1:0] r_boost;

    // read walk
    logic [IDX_W-1:0] r_idx;
    logic             r_have;
    logic [XW-1:0]    r_acc;
    logic             n_have;
    logic [XW-1:0]    n_acc;

    // result register
    logic                    r_out_valid;
    logic                    r_status;
    logic signed [RW-1:0]    r_read_value;
    logic                    r_boost_out;
    logic                    r_notify;
    logic signed [OW-1:0]    r_little_min;
    logic signed [OW-1:0]    r_big_min;
    logic signed [OW-1:0]    r_little_max;
    logic signed [OW-1:0]    r_big_max;

    logic [3:0]           w_div_eff;
    logic [XW-1:0]        w_div_x;
    logic [XW-1:0]        w_q;
    logic                 w_set;
    logic                 w_tgt_ok;
    logic [IDX_W-1:0]     w_tgt;
    logic                 w_notify;
    logic                 w_cmd_set;
    logic                 w_cmd_read;
    logic                 w_is_min;
    logic                 w_neg;
    logic                 w_above;
    logic [XW-1:0]        w_scaled;
    logic signed [EW-1:0] w_rd_little;
    logic signed [EW-1:0] w_rd_big;
    logic                 w_skip;
    logic                 w_big_ok;
    logic                 w_lit_ok;
    logic [XW-1:0]        w_big_val;
    logic                 w_b_win;
    logic                 w_l_win;
    logic                 w_have1;
    logic [XW-1:0]        w_acc1;
    logic signed [RW-1:0] w_read_value;

    // saturate a table entry to the result field range
    function automatic logic [OW-1:0] sat_entry(input logic [EW-1:0] e);
        logic [OW-1:0] v;
        if (!e[EW-1] && e[OW-1]) begin
            v = {1'b0, {(OW-1){1'b1}}};
        end else begin
            v = e[OW-1:0];
        end
        return v;
    endfunction

    assign w_div_eff = (r_little_divider == 4'd0) ? 4'd1 : r_little_divider;

    // shared divider: threshold or little entry of the walk
    assign w_div_x = i_ctrl.sel_entry ? w_rd_little[XW-1:0] : XW'(r_little_max_freq);

    cfla_divider #(
        .FREQ_BITS (FREQ_BITS)
    ) u_div (
        .i_clk (i_clk),
        .i_x   (w_div_x),
        .i_d   (w_div_eff),
        .o_q   (w_q)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_little_max_freq   <= FREQ_BITS'(cfla_pkg::RST_LITTLE_MAX_FREQ);
            r_little_divider    <= 4'(cfla_pkg::RST_LITTLE_DIVIDER);
            r_little_lock_floor <= FREQ_BITS'(cfla_pkg::RST_LITTLE_LOCK_FLOOR);
            r_big_lock_ceiling  <= FREQ_BITS'(cfla_pkg::RST_BIG_LOCK_CEILING);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cfla_pkg::CFG_LITTLE_MAX_FREQ:   r_little_max_freq   <= i_cfg_data;
                cfla_pkg::CFG_LITTLE_DIVIDER:    r_little_divider    <= i_cfg_data[3:0];
                cfla_pkg::CFG_LITTLE_LOCK_FLOOR: r_little_lock_floor <= i_cfg_data;
                cfla_pkg::CFG_BIG_LOCK_CEILING:  r_big_lock_ceiling  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_ctrl.latch_item) begin
            r_cmd  <= i_cmd;
            r_req  <= i_req;
            r_freq <= i_freq;
        end
    end

    // decode target entry of a store
    always_comb begin
        w_set    = 1'b0;
        w_tgt_ok = 1'b0;
        w_tgt    = '0;
        w_notify = 1'b0;
        case (r_cmd)
            cfla_pkg::CMD_SET_MIN: begin
                w_set    = 1'b1;
                w_tgt_ok = (32'(r_req) < NUM_REQUESTERS);
                w_tgt    = IDX_W'(r_req);
                w_notify = (32'(r_req) == USER_INDEX) || (32'(r_req) == TOUCH_INDEX)
                        || (32'(r_req) == FINGER_INDEX);
            end
            cfla_pkg::CMD_SET_USER_MAX: begin
                w_set    = 1'b1;
                w_tgt_ok = USER_OK;
                w_tgt    = IDX_W'(USER_INDEX);
                w_notify = 1'b1;
            end
            cfla_pkg::CMD_SET_OVER_MAX: begin
                w_set    = 1'b1;
                w_tgt_ok = OVER_OK;
                w_tgt    = IDX_W'(OVERLIMIT_INDEX);
                w_notify = 1'b1;
            end
            default: ;
        endcase
    end

    assign w_cmd_set  = w_set & w_tgt_ok;
    assign w_is_min   = (r_cmd == cfla_pkg::CMD_READ_MIN);
    assign w_cmd_read = w_is_min || (r_cmd == cfla_pkg::CMD_READ_MAX);

    // store mapping; divider output holds the threshold here
    assign w_neg    = r_freq[FREQ_BITS];
    assign w_above  = XW'(r_freq[FREQ_BITS-1:0]) > w_q;
    assign w_scaled = XW'(r_freq[FREQ_BITS-1:0]) * XW'(w_div_eff);

    // walk operands
    assign w_rd_little = w_is_min ? r_lmin[r_idx] : r_lmax[r_idx];
    assign w_rd_big    = w_is_min ? r_bmin[r_idx] : r_bmax[r_idx];
    assign w_skip      = !w_is_min && (32'(r_idx) == OVERLIMIT_INDEX);
    assign w_big_ok    = !w_rd_big[EW-1] && !w_skip;
    assign w_lit_ok    = !w_rd_little[EW-1] && !w_skip;
    assign w_big_val   = w_rd_big[XW-1:0];

    // fold big candidate then little quotient into the accumulator
    always_comb begin
        w_b_win = w_big_ok && (!r_have || (w_is_min ? (w_big_val > r_acc)
                                                    : (w_big_val < r_acc)));
        w_have1 = r_have | w_big_ok;
        w_acc1  = w_b_win ? w_big_val : r_acc;
        w_l_win = w_lit_ok && (!w_have1 || (w_is_min ? (w_q > w_acc1) : (w_q < w_acc1)));
        n_have  = w_have1 | w_lit_ok;
        n_acc   = w_l_win ? w_q : w_acc1;
    end

    // tables and boost flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REQUESTERS; k++) begin
                r_lmin[k] <= '1;
                r_bmin[k] <= '1;
                r_lmax[k] <= '1;
                r_bmax[k] <= '1;
            end
            r_boost <= '0;
        end else if (i_ctrl.write_entry) begin
            if (r_cmd == cfla_pkg::CMD_SET_MIN) begin
                if (w_neg) begin
                    r_lmin[w_tgt]  <= '1;
                    r_bmin[w_tgt]  <= '1;
                    r_boost[w_tgt] <= 1'b0;
                end else if (w_above) begin
                    r_lmin[w_tgt]  <= EW'(r_little_lock_floor);
                    r_bmin[w_tgt]  <= EW'(r_freq[FREQ_BITS-1:0]);
                    r_boost[w_tgt] <= 1'b1;
                end else begin
                    r_lmin[w_tgt]  <= EW'(w_scaled);
                    r_bmin[w_tgt]  <= '1;
                    r_boost[w_tgt] <= 1'b0;
                end
            end else begin
                if (w_neg) begin
                    r_lmax[w_tgt] <= '1;
                    r_bmax[w_tgt] <= '1;
                end else if (w_above) begin
                    r_lmax[w_tgt] <= '1;
                    r_bmax[w_tgt] <= EW'(r_freq[FREQ_BITS-1:0]);
                end else begin
                    r_lmax[w_tgt] <= EW'(w_scaled);
                    r_bmax[w_tgt] <= EW'(r_big_lock_ceiling);
                end
            end
        end
    end

    // walk index and accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctrl.idx_clear) begin
            r_idx <= '0;
        end else if (i_ctrl.idx_inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_ctrl.acc_clear) begin
            r_have <= 1'b0;
            r_acc  <= '0;
        end else if (i_ctrl.acc_step) begin
            r_have <= n_have;
            r_acc  <= n_acc;
        end
    end

    // aggregate saturated to the read range
    always_comb begin
        if (!r_have) begin
            w_read_value = '1;
        end else if (|r_acc[XW-1:FREQ_BITS]) begin
            w_read_value = {1'b0, {FREQ_BITS{1'b1}}};
        end else begin
            w_read_value = {1'b0, r_acc[FREQ_BITS-1:0]};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_status     <= !(w_cmd_set || w_cmd_read);
            r_read_value <= w_cmd_read ? w_read_value : '0;
            r_boost_out  <= |r_boost;
            r_notify     <= w_cmd_set & w_notify;
            r_little_min <= w_cmd_set ? sat_entry(r_lmin[w_tgt]) : '0;
            r_big_min    <= w_cmd_set ? sat_entry(r_bmin[w_tgt]) : '0;
            r_little_max <= w_cmd_set ? sat_entry(r_lmax[w_tgt]) : '0;
            r_big_max    <= w_cmd_set ? sat_entry(r_bmax[w_tgt]) : '0;
        end
    end

    assign o_stat.cmd_set  = w_cmd_set;
    assign o_stat.cmd_read = w_cmd_read;
    assign o_stat.idx_last = (r_idx == IDX_W'(NUM_REQUESTERS - 1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_read_value = r_read_value;
    assign o_boost      = r_boost_out;
    assign o_notify     = r_notify;
    assign o_little_min = r_little_min;
    assign o_big_min    = r_big_min;
    assign o_little_max = r_little_max;
    assign o_big_max    = r_big_max;

endmodule

>>> hdl/cfla_ctrl.sv
// controller state machine sequencing stores and aggregate reads
// depends on cfla_pkg
`timescale 1ns / 1ps

module cfla_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  cfla_pkg::t_stat  i_stat,
    output cfla_pkg::t_ctrl  o_ctrl
);

    cfla_pkg::t_state r_state;
    cfla_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfla_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_ctrl     = '0;
        o_s_tready = 1'b0;
        case (r_state)
            cfla_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_ctrl.latch_item = 1'b1;
                    n_state = cfla_pkg::S_DECODE;
                end
            end
            cfla_pkg::S_DECODE: begin
                o_ctrl.acc_clear = 1'b1;
                o_ctrl.idx_clear = 1'b1;
                if (i_stat.cmd_set) begin
                    n_state = cfla_pkg::S_TH_ISSUE;
                end else if (i_stat.cmd_read) begin
                    n_state = cfla_pkg::S_RD_ISSUE;
                end else begin
                    n_state = cfla_pkg::S_OUT;
                end
            end
            // threshold division in flight
            cfla_pkg::S_TH_ISSUE: begin
                n_state = cfla_pkg::S_TH_WAIT;
            end
            cfla_pkg::S_TH_WAIT: begin
                n_state = cfla_pkg::S_WRITE;
            end
            cfla_pkg::S_WRITE: begin
                o_ctrl.write_entry = 1'b1;
                n_state = cfla_pkg::S_OUT;
            end
            // each requester passes through the issue, wait and accumulate states
            cfla_pkg::S_RD_ISSUE: begin
                o_ctrl.sel_entry = 1'b1;
                n_state = cfla_pkg::S_RD_WAIT;
            end
            cfla_pkg::S_RD_WAIT: begin
                o_ctrl.sel_entry = 1'b1;
                n_state = cfla_pkg::S_RD_ACC;
            end
            cfla_pkg::S_RD_ACC: begin
                o_ctrl.sel_entry = 1'b1;
                o_ctrl.acc_step  = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = cfla_pkg::S_OUT;
                end else begin
                    o_ctrl.idx_inc = 1'b1;
                    n_state = cfla_pkg::S_RD_ISSUE;
                end
            end
            cfla_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    o_ctrl.out_load = 1'b1;
                    n_state = cfla_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cfla_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/cpu_freq_limit_aggregator.sv
// an item is latched in idle and decoded; a bad command goes on to output, a store issues and
// waits on the threshold division, then writes its entry, and a read walks the requesters through
// the shared two-stage divider in issue, wait and accumulate states; all then return to idle
// reset is synchronous, active low: limit tables return to no limit, boost flags clear,
// configuration returns to its defaults; the block accepts items as soon as reset is released
// depends on cfla_pkg, cfla_ctrl, cfla_datapath and the assertion macro header
`timescale 1ns / 1ps
`include "cpu_freq_limit_aggregator_defines.svh"

module cpu_freq_limit_aggregator #(
    parameter int NUM_REQUESTERS  = 8,
    parameter int USER_INDEX      = 0,
    parameter int TOUCH_INDEX     = 1,
    parameter int FINGER_INDEX    = 2,
    parameter int OVERLIMIT_INDEX = 3,
    parameter int FREQ_BITS       = 22
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_s_tvalid,
    output logic                                     o_s_tready,
    // cmd, requester, freq
    input  logic [((FREQ_BITS + 14) / 8) * 8 - 1:0]  i_s_tdata,
    output logic                                     o_m_tvalid,
    input  logic                                     i_m_tready,
    // status, read_value, boost_level, notify,
    // out_little_min, out_big_min, out_little_max, out_big_max
    output logic [((5 * FREQ_BITS + 27) / 8) * 8 - 1:0] o_m_tdata,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [cfla_pkg::CFG_INDEX_W-1:0]         i_cfg_index,
    input  logic [FREQ_BITS-1:0]                     i_cfg_data
);

    localparam int OUT_W = ((5 * FREQ_BITS + 27) / 8) * 8;
    localparam int OW    = FREQ_BITS + 4;
    localparam int RW    = FREQ_BITS + 1;

    cfla_pkg::t_ctrl w_ctrl;
    cfla_pkg::t_stat w_stat;

    logic                 w_status;
    logic signed [RW-1:0] w_read_value;
    logic                 w_boost;
    logic                 w_notify;
    logic signed [OW-1:0] w_little_min;
    logic signed [OW-1:0] w_big_min;
    logic signed [OW-1:0] w_little_max;
    logic signed [OW-1:0] w_big_max;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    cfla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    cfla_datapath #(
        .NUM_REQUESTERS  (NUM_REQUESTERS),
        .USER_INDEX      (USER_INDEX),
        .TOUCH_INDEX     (TOUCH_INDEX),
        .FINGER_INDEX    (FINGER_INDEX),
        .OVERLIMIT_INDEX (OVERLIMIT_INDEX),
        .FREQ_BITS       (FREQ_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .o_stat       (w_stat),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (i_s_tdata[2:0]),
        .i_req        (i_s_tdata[5:3]),
        .i_freq       (i_s_tdata[FREQ_BITS+6:6]),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (o_m_tvalid),
        .o_status     (w_status),
        .o_read_value (w_read_value),
        .o_boost      (w_boost),
        .o_notify     (w_notify),
        .o_little_min (w_little_min),
        .o_big_min    (w_big_min),
        .o_little_max (w_little_max),
        .o_big_max    (w_big_max)
    );

    // pack result fields, lowest first, zero padded
    assign o_m_tdata = OUT_W'({w_big_max, w_little_max, w_big_min, w_little_min,
                               w_notify, w_boost, w_read_value, w_status});

    // checks on sequencing
    `CFLA_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "input taken while busy")
    `CFLA_ASSERT_IMP(a_write_only_valid, i_clk, i_rst_n, w_ctrl.write_entry, w_stat.cmd_set, "table write without a valid store")
    `CFLA_ASSERT_IMP(a_load_only_free, i_clk, i_rst_n, w_ctrl.out_load, w_stat.out_free, "result overwritten before transfer")
    `CFLA_ASSERT_IMP(a_error_clean, i_clk, i_rst_n, o_m_tvalid && w_status, (w_read_value == '0) && !w_notify && (w_little_min == '0), "error result carries data")

endmodule
